[hw/rtl/dqb_pkg.sv]
// Shared types, constants and byte-select functions of the DNS query builder.
// Used by the channel interfaces, the front queue, the back sequencer and the top level.
`timescale 1ns / 1ps

package dqb_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int NAME_W      = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CNT_W       = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam int HEADER_BYTES = 12;
    localparam int TAIL_BYTES   = 5;

    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FLAGS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_TYPE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_CLASS  = 2'd2;

    localparam logic [WORD_W-1:0] RST_HEADER_FLAGS = 16'h0100;
    localparam logic [WORD_W-1:0] RST_QUERY_TYPE   = 16'h0001;
    localparam logic [WORD_W-1:0] RST_QUERY_CLASS  = 16'h0001;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_STORE,
        ST_CHECK,
        ST_LEN,
        ST_DATA,
        ST_TAIL
    } t_state;

    typedef struct packed {
        logic [BYTE_W-1:0] char_byte;
        logic              last_char;
        logic [WORD_W-1:0] query_id;
        logic              first;
        logic              is_dot;
    } t_cmd;

    typedef struct packed {
        logic [WORD_W-1:0] header_flags;
        logic [WORD_W-1:0] query_type;
        logic [WORD_W-1:0] query_class;
    } t_cfg;

    function automatic logic [BYTE_W-1:0] header_byte(input logic [CNT_W-1:0] idx,
                                                      input logic [WORD_W-1:0] id,
                                                      input logic [WORD_W-1:0] flags);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd0:    b = id[15:8];
            4'd1:    b = id[7:0];
            4'd2:    b = flags[15:8];
            4'd3:    b = flags[7:0];
            4'd5:    b = 8'd1;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] tail_byte(input logic [CNT_W-1:0] idx,
                                                    input logic [WORD_W-1:0] qtype,
                                                    input logic [WORD_W-1:0] qclass);
        logic [BYTE_W-1:0] b;
        unique case (idx)
            4'd1:    b = qtype[15:8];
            4'd2:    b = qtype[7:0];
            4'd3:    b = qclass[15:8];
            4'd4:    b = qclass[7:0];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/dqb_char_if.sv]
// Input channel of the DNS query builder: one hostname character per transaction.
// Depends on dqb_pkg for field widths.
`timescale 1ns / 1ps

interface dqb_char_if;
    logic                      valid;
    logic                      ready;
    logic [dqb_pkg::BYTE_W-1:0] char_byte;
    logic                      last_char;
    logic [dqb_pkg::WORD_W-1:0] query_id;

    modport source (output valid, output char_byte, output last_char, output query_id,
                    input ready);
    modport sink   (input valid, input char_byte, input last_char, input query_id,
                    output ready);
endinterface

[hw/rtl/dqb_byte_if.sv]
// Output channel of the DNS query builder: one message byte per transaction.
// Depends on dqb_pkg for field widths.
`timescale 1ns / 1ps

interface dqb_byte_if;
    logic                      valid;
    logic                      ready;
    logic [dqb_pkg::BYTE_W-1:0] out_byte;
    logic                      last_byte;
    logic [dqb_pkg::NAME_W-1:0] query_length;
    logic                      label_truncated;

    modport source (output valid, output out_byte, output last_byte, output query_length,
                    output label_truncated, input ready);
    modport sink   (input valid, input out_byte, input last_byte, input query_length,
                    input label_truncated, output ready);
endinterface

[hw/rtl/dqb_front.sv]
// Front end: accepts characters, tags the first one of a query and dots,
// and holds them in a short command queue. Depends on dqb_pkg and dqb_char_if.
`timescale 1ns / 1ps

module dqb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    dqb_char_if.sink        i_char,
    output dqb_pkg::t_cmd   o_cmd,
    output logic            o_cmd_valid,
    input  logic            i_cmd_pop
);

    dqb_pkg::t_cmd                 r_q [dqb_pkg::QUEUE_DEPTH];
    logic [dqb_pkg::QPTR_W-1:0]    r_wr;
    logic [dqb_pkg::QPTR_W-1:0]    r_rd;
    logic [dqb_pkg::QCNT_W-1:0]    r_cnt;
    logic                          r_in_query;
    logic                          push;
    logic                          pop;
    dqb_pkg::t_cmd                 new_cmd;

    assign i_char.ready = (r_cnt != dqb_pkg::QCNT_W'(dqb_pkg::QUEUE_DEPTH));
    assign push         = i_char.valid && i_char.ready;
    assign o_cmd_valid  = (r_cnt != '0);
    assign pop          = i_cmd_pop && o_cmd_valid;
    assign o_cmd        = r_q[r_rd];

    always_comb begin
        new_cmd.char_byte = i_char.char_byte;
        new_cmd.last_char = i_char.last_char;
        new_cmd.query_id  = i_char.query_id;
        new_cmd.first     = !r_in_query;
        new_cmd.is_dot    = (i_char.char_byte == dqb_pkg::DOT_CHAR);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= new_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr       <= '0;
            r_rd       <= '0;
            r_cnt      <= '0;
            r_in_query <= 1'b0;
        end else begin
            if (push) begin
                r_wr       <= r_wr + 1'b1;
                r_in_query <= !i_char.last_char;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

[hw/rtl/dqb_back.sv]
// Back end: sequencer that writes the header, buffers labels in a small memory,
// flushes them as length and characters, and ends the query with root, type and class.
// Depends on dqb_pkg and dqb_byte_if.
`timescale 1ns / 1ps

module dqb_back #(
    parameter int LABEL_MAX = 32,
    parameter int NAME_MAX  = 255
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dqb_pkg::t_cmd   i_cmd,
    input  logic            i_cmd_valid,
    output logic            o_cmd_pop,
    input  dqb_pkg::t_cfg   i_cfg,
    dqb_byte_if.source      o_byte
);

    localparam int CW = $clog2(LABEL_MAX + 1);
    localparam int AW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;

    dqb_pkg::t_state               r_state, n_state;
    dqb_pkg::t_cmd                 r_cmd, n_cmd;
    logic [dqb_pkg::CNT_W-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]                 r_label_count, n_label_count;
    logic                          r_ovf, n_ovf;
    logic [dqb_pkg::NAME_W-1:0]    r_name_bytes, n_name_bytes;
    logic [CW-1:0]                 r_len, n_len;
    logic                          r_trunc, n_trunc;
    logic [CW-1:0]                 r_idx, n_idx;

    logic [dqb_pkg::BYTE_W-1:0]    r_mem [LABEL_MAX];
    logic [dqb_pkg::BYTE_W-1:0]    r_rd_data;
    logic                          mem_we;
    logic [AW-1:0]                 mem_addr;
    logic [CW-1:0]                 rd_idx;

    logic                          r_out_valid;
    logic [dqb_pkg::BYTE_W-1:0]    r_out_byte;
    logic                          r_out_last;
    logic [dqb_pkg::NAME_W-1:0]    r_out_len;
    logic                          r_out_trunc;

    logic                          can_emit;
    logic                          emit;
    logic                          emit_fire;
    logic [dqb_pkg::BYTE_W-1:0]    emit_byte;
    logic                          emit_last;
    logic [dqb_pkg::NAME_W-1:0]    emit_len;
    logic                          emit_trunc;

    logic [9:0]                    nb_ext;
    logic [9:0]                    avail;
    logic                          flush_go;
    logic [CW-1:0]                 eff_len;
    logic                          eff_trunc;
    logic [dqb_pkg::NAME_W-1:0]    total;

    assign can_emit  = !r_out_valid || o_byte.ready;
    assign emit_fire = emit && can_emit;
    assign o_cmd_pop = (r_state == dqb_pkg::ST_IDLE) && i_cmd_valid;

    assign nb_ext    = {1'b0, r_name_bytes};
    assign avail     = 10'(NAME_MAX) - 10'd2 - nb_ext;
    assign flush_go  = (r_label_count != '0) && ((nb_ext + 10'd3) <= 10'(NAME_MAX));
    assign eff_trunc = r_ovf || (10'(r_label_count) > avail);
    assign eff_len   = (10'(r_label_count) > avail) ? avail[CW-1:0] : r_label_count;
    assign total     = r_name_bytes
                     + dqb_pkg::NAME_W'(dqb_pkg::HEADER_BYTES + dqb_pkg::TAIL_BYTES);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dqb_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_state = i_cmd.first ? dqb_pkg::ST_HEADER : dqb_pkg::ST_STORE;
                end
            end
            dqb_pkg::ST_HEADER: begin
                if (can_emit && r_cnt == dqb_pkg::CNT_W'(dqb_pkg::HEADER_BYTES - 1)) begin
                    n_state = dqb_pkg::ST_STORE;
                end
            end
            dqb_pkg::ST_STORE: begin
                n_state = (r_cmd.is_dot || r_cmd.last_char) ? dqb_pkg::ST_CHECK
                                                            : dqb_pkg::ST_IDLE;
            end
            dqb_pkg::ST_CHECK: begin
                if (flush_go) begin
                    n_state = dqb_pkg::ST_LEN;
                end else begin
                    n_state = r_cmd.last_char ? dqb_pkg::ST_TAIL : dqb_pkg::ST_IDLE;
                end
            end
            dqb_pkg::ST_LEN: begin
                if (can_emit) begin
                    n_state = dqb_pkg::ST_DATA;
                end
            end
            dqb_pkg::ST_DATA: begin
                if (can_emit && r_idx == r_len - 1'b1) begin
                    n_state = r_cmd.last_char ? dqb_pkg::ST_TAIL : dqb_pkg::ST_IDLE;
                end
            end
            dqb_pkg::ST_TAIL: begin
                if (can_emit && r_cnt == dqb_pkg::CNT_W'(dqb_pkg::TAIL_BYTES - 1)) begin
                    n_state = dqb_pkg::ST_IDLE;
                end
            end
            default: n_state = dqb_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cmd         = r_cmd;
        n_cnt         = r_cnt;
        n_label_count = r_label_count;
        n_ovf         = r_ovf;
        n_name_bytes  = r_name_bytes;
        n_len         = r_len;
        n_trunc       = r_trunc;
        n_idx         = r_idx;
        mem_we        = 1'b0;
        mem_addr      = r_label_count[AW-1:0];
        emit          = 1'b0;
        emit_byte     = '0;
        emit_last     = 1'b0;
        emit_len      = '0;
        emit_trunc    = 1'b0;
        unique case (r_state)
            dqb_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd = i_cmd;
                    n_cnt = '0;
                    if (i_cmd.first) begin
                        n_name_bytes  = '0;
                        n_label_count = '0;
                        n_ovf         = 1'b0;
                    end
                end
            end
            dqb_pkg::ST_HEADER: begin
                emit      = 1'b1;
                emit_byte = dqb_pkg::header_byte(r_cnt, r_cmd.query_id, i_cfg.header_flags);
                if (can_emit) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            dqb_pkg::ST_STORE: begin
                if (!r_cmd.is_dot) begin
                    if (r_label_count < CW'(LABEL_MAX)) begin
                        mem_we        = 1'b1;
                        n_label_count = r_label_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            dqb_pkg::ST_CHECK: begin
                n_label_count = '0;
                n_ovf         = 1'b0;
                n_cnt         = '0;
                n_idx         = '0;
                n_len         = eff_len;
                n_trunc       = eff_trunc;
            end
            dqb_pkg::ST_LEN: begin
                emit       = 1'b1;
                emit_byte  = dqb_pkg::BYTE_W'(r_len);
                emit_trunc = r_trunc;
                if (can_emit) begin
                    n_name_bytes = r_name_bytes + 1'b1 + dqb_pkg::NAME_W'(r_len);
                end
            end
            dqb_pkg::ST_DATA: begin
                emit      = 1'b1;
                emit_byte = r_rd_data;
                if (can_emit) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            dqb_pkg::ST_TAIL: begin
                emit      = 1'b1;
                emit_byte = dqb_pkg::tail_byte(r_cnt, i_cfg.query_type, i_cfg.query_class);
                if (r_cnt == dqb_pkg::CNT_W'(dqb_pkg::TAIL_BYTES - 1)) begin
                    emit_last = 1'b1;
                    emit_len  = total;
                    if (can_emit) begin
                        n_name_bytes = '0;
                    end
                end
                if (can_emit) begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    assign rd_idx = ((r_state == dqb_pkg::ST_DATA) && can_emit) ? r_idx + 1'b1 : r_idx;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_cmd.char_byte;
        end
        r_rd_data <= r_mem[rd_idx[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_len   <= n_len;
        r_trunc <= n_trunc;
        r_idx   <= n_idx;
        if (emit_fire) begin
            r_out_byte  <= emit_byte;
            r_out_last  <= emit_last;
            r_out_len   <= emit_len;
            r_out_trunc <= emit_trunc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= dqb_pkg::ST_IDLE;
            r_cnt         <= '0;
            r_label_count <= '0;
            r_ovf         <= 1'b0;
            r_name_bytes  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cnt         <= n_cnt;
            r_label_count <= n_label_count;
            r_ovf         <= n_ovf;
            r_name_bytes  <= n_name_bytes;
            if (emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_byte.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_byte.valid           = r_out_valid;
    assign o_byte.out_byte        = r_out_byte;
    assign o_byte.last_byte       = r_out_last;
    assign o_byte.query_length    = r_out_len;
    assign o_byte.label_truncated = r_out_trunc;

    a_label_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_label_count <= CW'(LABEL_MAX))
        else $error("label count exceeds the label buffer");

    a_name_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        10'(r_name_bytes) <= 10'(NAME_MAX) - 10'd1)
        else $error("encoded name leaves no room for the root byte");

    a_data_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqb_pkg::ST_DATA) |-> (r_idx < r_len) && (r_len != '0))
        else $error("label read runs past its length");

    a_last_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |->
            (r_out_len >= dqb_pkg::NAME_W'(dqb_pkg::HEADER_BYTES + dqb_pkg::TAIL_BYTES)))
        else $error("final byte carries a short message length");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dqb_pkg::ST_TAIL && !can_emit) |=> (r_state == dqb_pkg::ST_TAIL))
        else $error("tail sequencer advanced while the output was stalled");

endmodule

[hw/rtl/dns_query_builder.sv]
// Top level of the DNS query builder: configuration registers, front queue and back sequencer.
// Depends on dqb_pkg, dqb_char_if, dqb_byte_if, dqb_front and dqb_back.
//
// Characters enter through a four-entry command queue and are carried out by a back
// sequencer that produces at most one message byte per cycle into an output register.
// An ordinary character is taken from the queue in ST_IDLE and written into the label
// buffer in ST_STORE. The first character of a query first passes through ST_HEADER for
// the twelve header bytes; a label flush goes through ST_CHECK, then ST_LEN for the length
// byte and ST_DATA for the label characters; the end of a query goes through ST_TAIL for
// the root byte, type and class. Output stalls hold the byte-emitting states. The label
// buffer holds LABEL_MAX bytes and needs no clearing after reset.
`timescale 1ns / 1ps

module dns_query_builder #(
    parameter int LABEL_MAX = 32,
    parameter int NAME_MAX  = 255
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dqb_char_if.sink                      i_char,
    dqb_byte_if.source                    o_byte,
    input  logic                          i_cfg_we,
    input  logic [dqb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dqb_pkg::WORD_W-1:0]    i_cfg_data
);

    dqb_pkg::t_cfg r_cfg;
    dqb_pkg::t_cmd cmd;
    logic          cmd_valid;
    logic          cmd_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_flags <= dqb_pkg::RST_HEADER_FLAGS;
            r_cfg.query_type   <= dqb_pkg::RST_QUERY_TYPE;
            r_cfg.query_class  <= dqb_pkg::RST_QUERY_CLASS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dqb_pkg::CFG_HEADER_FLAGS: r_cfg.header_flags <= i_cfg_data;
                dqb_pkg::CFG_QUERY_TYPE:   r_cfg.query_type   <= i_cfg_data;
                dqb_pkg::CFG_QUERY_CLASS:  r_cfg.query_class  <= i_cfg_data;
                default:                   r_cfg              <= r_cfg;
            endcase
        end
    end

    dqb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (i_char),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    dqb_back #(
        .LABEL_MAX (LABEL_MAX),
        .NAME_MAX  (NAME_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cfg       (r_cfg),
        .o_byte      (o_byte)
    );

endmodule
